>>> rtl/mmrs_pkg.sv
// Shared types and constants for the MIDI running-status merge FIFO.
package mmrs_pkg;

    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int CHAN_W  = 5;
    localparam int CNT_W   = 32;
    localparam int LEVEL_W = 11;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_HEAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

    // Status byte classes
    localparam logic [BYTE_W-1:0] STATUS_BIT    = 8'h80;
    localparam logic [BYTE_W-1:0] SYSTEM_BASE   = 8'hF0;
    localparam logic [BYTE_W-1:0] REALTIME_BASE = 8'hF8;
    localparam logic [CHAN_W-1:0] CHANNEL_COUNT = 5'd16;

    // Per-transaction result, minus the popped byte that comes from the RAM
    typedef struct packed {
        logic                 byte_valid;
        logic                 message_dropped;
        logic [LEVEL_W-1:0]   queue_level;
        logic [CNT_W-1:0]     dropped_total;
        logic [CNT_W-1:0]     delivered_total;
    } mmrs_status_t;

endpackage

>>> rtl/mmrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mmrs_ctrl.sv
// Merge control: pointers, counts, running status, drop logic and counters.
module mmrs_ctrl #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [mmrs_pkg::MODE_W-1:0]      mode,
    input  logic [mmrs_pkg::BYTE_W-1:0]      data_byte,
    input  logic [mmrs_pkg::LEN_W-1:0]       msg_length,
    input  logic [mmrs_pkg::CHAN_W-1:0]      force_channel,
    output logic                             ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_waddr,
    output logic [mmrs_pkg::BYTE_W-1:0]      ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_raddr,
    output mmrs_pkg::mmrs_status_t           status
);
    import mmrs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]     committed_reg, committed_next;
    logic [CW-1:0]     uncommitted_reg, uncommitted_next;
    logic [BYTE_W-1:0] run_status_reg, run_status_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic              discard_reg, discard_next;
    logic [CNT_W-1:0]  dropped_cnt_reg, dropped_cnt_next;
    logic [CNT_W-1:0]  delivered_cnt_reg, delivered_cnt_next;

    logic              msg_open;
    logic [PW-1:0]     unc_ptr;
    logic [PW-1:0]     wr_rewind;
    logic [PW-1:0]     head_wr_ptr;
    logic [BYTE_W-1:0] head_run_status;
    logic              voice;
    logic              chan_ok;
    logic [BYTE_W-1:0] head_status;
    logic              omit;
    logic [LEN_W-1:0]  need;
    logic [SW-1:0]     fit_sum;
    logic              fits;
    logic [LEN_W-1:0]  len_rest;
    logic [CNT_W:0]    drop_sum;
    logic [LEN_W-1:0]  data_rest;
    logic              pop_ok;
    logic              drop_flag;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Head decode: abandon an open message, classify and rewrite the status
    always_comb
    begin
        msg_open  = (remaining_reg != '0) || (uncommitted_reg != '0);
        unc_ptr   = PW'(uncommitted_reg);
        if (wr_ptr_reg >= unc_ptr)
        begin
            wr_rewind = wr_ptr_reg - unc_ptr;
        end
        else
        begin
            wr_rewind = PW'(CW'(QUEUE_DEPTH) - CW'(unc_ptr) + CW'(wr_ptr_reg));
        end
        head_wr_ptr     = msg_open ? wr_rewind : wr_ptr_reg;
        head_run_status = msg_open ? '0 : run_status_reg;
        voice   = (data_byte >= STATUS_BIT) && (data_byte < SYSTEM_BASE);
        chan_ok = (force_channel != '0) && (force_channel <= CHANNEL_COUNT);
        if (voice && chan_ok)
        begin
            head_status = {data_byte[7:4], 4'(force_channel - 5'd1)};
        end
        else
        begin
            head_status = data_byte;
        end
        omit     = voice && (head_status == head_run_status) && (msg_length > 11'd1);
        need     = omit ? (msg_length - 11'd1) : msg_length;
        fit_sum  = SW'(committed_reg) + SW'(need);
        fits     = fit_sum <= SW'(QUEUE_DEPTH);
        len_rest = msg_length - 11'd1;
        drop_sum = {1'b0, dropped_cnt_reg} + (CNT_W + 1)'(msg_length);
    end

    // Next state per transaction
    always_comb
    begin
        rd_ptr_next        = rd_ptr_reg;
        wr_ptr_next        = wr_ptr_reg;
        committed_next     = committed_reg;
        uncommitted_next   = uncommitted_reg;
        run_status_next    = run_status_reg;
        remaining_next     = remaining_reg;
        discard_next       = discard_reg;
        dropped_cnt_next   = dropped_cnt_reg;
        delivered_cnt_next = delivered_cnt_reg;
        ram_we             = 1'b0;
        ram_waddr          = wr_ptr_reg;
        ram_wdata          = data_byte;
        ram_re             = 1'b0;
        ram_raddr          = rd_ptr_reg;
        pop_ok             = 1'b0;
        drop_flag          = 1'b0;
        data_rest          = remaining_reg - 11'd1;

        if (take)
        begin
            case (mode)
                MODE_HEAD:
                begin
                    if (msg_length != '0)
                    begin
                        wr_ptr_next      = head_wr_ptr;
                        uncommitted_next = '0;
                        run_status_next  = head_run_status;
                        remaining_next   = len_rest;
                        if (!fits)
                        begin
                            // Drop the whole message, count its bytes
                            drop_flag        = 1'b1;
                            dropped_cnt_next = drop_sum[CNT_W] ? '1 : drop_sum[CNT_W-1:0];
                            discard_next     = len_rest != '0;
                        end
                        else
                        begin
                            discard_next = 1'b0;
                            if (!omit)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = head_wr_ptr;
                                ram_wdata        = head_status;
                                wr_ptr_next      = advance(head_wr_ptr);
                                uncommitted_next = CW'(1);
                            end
                            if (voice)
                            begin
                                run_status_next = head_status;
                            end
                            else if (head_status < REALTIME_BASE)
                            begin
                                run_status_next = '0;
                            end
                            // Commit a single-byte message at once
                            if (len_rest == '0)
                            begin
                                committed_next   = committed_reg + uncommitted_next;
                                uncommitted_next = '0;
                            end
                        end
                    end
                end
                MODE_DATA:
                begin
                    if (remaining_reg != '0)
                    begin
                        remaining_next = data_rest;
                        if (discard_reg)
                        begin
                            discard_next = data_rest != '0;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = wr_ptr_reg;
                            ram_wdata   = data_byte;
                            wr_ptr_next = advance(wr_ptr_reg);
                            if (data_rest == '0)
                            begin
                                committed_next   = committed_reg + uncommitted_reg + CW'(1);
                                uncommitted_next = '0;
                            end
                            else
                            begin
                                uncommitted_next = uncommitted_reg + CW'(1);
                            end
                        end
                    end
                end
                MODE_POP:
                begin
                    if (committed_reg != '0)
                    begin
                        pop_ok         = 1'b1;
                        ram_re         = 1'b1;
                        ram_raddr      = rd_ptr_reg;
                        rd_ptr_next    = advance(rd_ptr_reg);
                        committed_next = committed_reg - CW'(1);
                        if (delivered_cnt_reg != '1)
                        begin
                            delivered_cnt_next = delivered_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    // Unused mode: report status only
                end
            endcase
        end
    end

    // Result fields for the accepted transaction
    always_comb
    begin
        status.byte_valid      = pop_ok;
        status.message_dropped = drop_flag;
        status.queue_level     = LEVEL_W'(committed_next);
        status.dropped_total   = dropped_cnt_next;
        status.delivered_total = delivered_cnt_next;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            committed_reg     <= '0;
            uncommitted_reg   <= '0;
            run_status_reg    <= '0;
            remaining_reg     <= '0;
            discard_reg       <= 1'b0;
            dropped_cnt_reg   <= '0;
            delivered_cnt_reg <= '0;
        end
        else
        begin
            rd_ptr_reg        <= rd_ptr_next;
            wr_ptr_reg        <= wr_ptr_next;
            committed_reg     <= committed_next;
            uncommitted_reg   <= uncommitted_next;
            run_status_reg    <= run_status_next;
            remaining_reg     <= remaining_next;
            discard_reg       <= discard_next;
            dropped_cnt_reg   <= dropped_cnt_next;
            delivered_cnt_reg <= delivered_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(committed_reg) + (CW + 1)'(uncommitted_reg) <= (CW + 1)'(QUEUE_DEPTH))
        else $error("committed plus uncommitted bytes exceed the queue depth");
    a_discard_open: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (remaining_reg != '0))
        else $error("discard flag set with no message open");
    a_uncommitted_open: assert property (@(posedge clk) disable iff (!rst_n)
        (uncommitted_reg != '0) |-> (remaining_reg != '0))
        else $error("uncommitted bytes left after the last byte of a message");
    a_pop_grows_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && (delivered_cnt_reg != '1)) |=> (delivered_cnt_reg == $past(delivered_cnt_reg) + CNT_W'(1)))
        else $error("delivered count did not advance on a pop");
`endif

endmodule

>>> rtl/midi_merge_running_status_fifo.sv
// A result is registered in stage 1 and then in the output stage before it is offered.
// Throughput: one transaction per cycle while the output drains; the state update and
// the byte RAM access both complete in the accept cycle, and RAM read data is registered.
// A held result does not stop input: a second stage absorbs one more transaction.
// Reset: rst_n clears pointers, counts, running status and counters at once;
// the byte RAM has no reset and is read only at committed entries.
module midi_merge_running_status_fifo #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mmrs_pkg::MODE_W-1:0]      mode,
    input  logic [mmrs_pkg::BYTE_W-1:0]      data_byte,
    input  logic [mmrs_pkg::LEN_W-1:0]       msg_length,
    input  logic [mmrs_pkg::CHAN_W-1:0]      force_channel,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             byte_valid,
    output logic [mmrs_pkg::BYTE_W-1:0]      out_byte,
    output logic                             message_dropped,
    output logic [mmrs_pkg::LEVEL_W-1:0]     queue_level,
    output logic [mmrs_pkg::CNT_W-1:0]       dropped_total,
    output logic [mmrs_pkg::CNT_W-1:0]       delivered_total
);
    import mmrs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic              take;
    logic              move;
    logic              ram_we;
    logic [PW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    mmrs_status_t      status;

    logic              p1_valid_reg;
    mmrs_status_t      p1_status_reg;
    logic              out_valid_reg;
    mmrs_status_t      out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    // Stage 1 drains when the output slot is free or being taken
    assign move     = p1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !p1_valid_reg || move;
    assign take     = in_valid && in_ready;

    mmrs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .mode          (mode),
        .data_byte     (data_byte),
        .msg_length    (msg_length),
        .force_channel (force_channel),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .status        (status)
    );

    mmrs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads; RAM read data is held until stage 1 drains
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p1_status_reg <= status;
        end
        if (move)
        begin
            out_status_reg <= p1_status_reg;
            out_byte_reg   <= p1_status_reg.byte_valid ? ram_rdata : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign byte_valid      = out_status_reg.byte_valid;
    assign out_byte        = out_byte_reg;
    assign message_dropped = out_status_reg.message_dropped;
    assign queue_level     = out_status_reg.queue_level;
    assign dropped_total   = out_status_reg.dropped_total;
    assign delivered_total = out_status_reg.delivered_total;

endmodule

>>> test/midi_merge_running_status_fifo_tb.sv
// Self-checking testbench for the MIDI running-status merge FIFO.
`timescale 1ns / 100ps

module midi_merge_running_status_fifo_tb;
    import mmrs_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT_FIRST = 400;
    localparam int HOLD_AT_SECOND = 1000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [CHAN_W-1:0] chan;
    } midi_req_t;

    typedef struct packed {
        logic               byte_valid;
        logic [BYTE_W-1:0]  out_byte;
        logic               dropped;
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   dropped_total;
        logic [CNT_W-1:0]   delivered_total;
    } merge_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [MODE_W-1:0] mode = MODE_HEAD;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [LEN_W-1:0] msg_length = '0;
    logic [CHAN_W-1:0] force_channel = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic message_dropped;
    logic [LEVEL_W-1:0] queue_level;
    logic [CNT_W-1:0] dropped_total;
    logic [CNT_W-1:0] delivered_total;

    midi_req_t midi_requests [$];
    merge_result_t expected_results [$];
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int steady_left [2] = '{0, 0};
    int idle_cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    logic [BYTE_W-1:0] gen_voice = 8'h90;
    int gen_chan = 0;

    // Merge state mirror
    logic [BYTE_W-1:0] ring [DEPTH];
    int rd_ptr = 0;
    int wr_ptr = 0;
    int committed = 0;
    int uncommitted = 0;
    int remaining = 0;
    bit discard = 1'b0;
    logic [BYTE_W-1:0] run_status = '0;
    logic [CNT_W-1:0] dropped_bytes = '0;
    logic [CNT_W-1:0] popped_bytes = '0;

    midi_merge_running_status_fifo #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .data_byte(data_byte),
        .msg_length(msg_length),
        .force_channel(force_channel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .byte_valid(byte_valid),
        .out_byte(out_byte),
        .message_dropped(message_dropped),
        .queue_level(queue_level),
        .dropped_total(dropped_total),
        .delivered_total(delivered_total)
    );

    always #10 clk = ~clk;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    function automatic void store_byte(input logic [BYTE_W-1:0] b);
        ring[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        uncommitted++;
    endfunction

    function automatic void commit_if_done();
        if (remaining == 0)
        begin
            committed += uncommitted;
            uncommitted = 0;
        end
    endfunction

    // Advance the merge state by one transaction and return what the block should report
    function automatic merge_result_t merge_item(input midi_req_t req);
        merge_result_t r;
        logic [BYTE_W-1:0] st;
        bit voice;
        bit omit;
        int need;
        r = '0;
        st = req.data;
        case (req.mode)
            MODE_HEAD:
            begin
                if (req.len != 0)
                begin
                    if (remaining != 0 || uncommitted != 0)
                    begin
                        // abandon the open message; next voice status goes out in full
                        wr_ptr = (wr_ptr + DEPTH - uncommitted % DEPTH) % DEPTH;
                        uncommitted = 0;
                        remaining = 0;
                        discard = 1'b0;
                        run_status = '0;
                    end
                    voice = st >= STATUS_BIT && st < SYSTEM_BASE;
                    if (voice && req.chan >= 1 && req.chan <= CHANNEL_COUNT)
                        st = (st & SYSTEM_BASE) | {3'b000, req.chan - 5'd1};
                    omit = voice && st == run_status && req.len > 1;
                    need = omit ? req.len - 1 : req.len;
                    if (committed + need > DEPTH)
                    begin
                        dropped_bytes = sat_add(dropped_bytes, CNT_W'(req.len));
                        remaining = req.len - 1;
                        discard = remaining != 0;
                        r.dropped = 1'b1;
                    end
                    else
                    begin
                        discard = 1'b0;
                        if (!omit)
                            store_byte(st);
                        remaining = req.len - 1;
                        if (voice)
                            run_status = st;
                        else if (st < REALTIME_BASE)
                            run_status = '0;
                        commit_if_done();
                    end
                end
            end
            MODE_DATA:
            begin
                if (remaining != 0)
                begin
                    remaining--;
                    if (discard)
                    begin
                        if (remaining == 0)
                            discard = 1'b0;
                    end
                    else
                    begin
                        store_byte(req.data);
                        commit_if_done();
                    end
                end
            end
            MODE_POP:
            begin
                if (committed != 0)
                begin
                    r.byte_valid = 1'b1;
                    r.out_byte = ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    committed--;
                    popped_bytes = sat_add(popped_bytes, CNT_W'(1));
                end
            end
            default:
            begin
            end
        endcase
        r.level = LEVEL_W'(committed);
        r.dropped_total = dropped_bytes;
        r.delivered_total = popped_bytes;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap(input int side);
        int r;
        if (steady_left[side] != 0)
        begin
            steady_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            steady_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_data();
        if ($urandom_range(0, 9) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return BYTE_W'($urandom_range(0, 127));
    endfunction

    task automatic add_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d,
                            input int len, input int chan);
        midi_req_t req;
        req.mode = m;
        req.data = d;
        req.len = LEN_W'(len);
        req.chan = CHAN_W'(chan);
        midi_requests.insert(midi_requests.size(), req);
    endtask

    task automatic add_pop();
        add_item(MODE_POP, rand_data(), $urandom_range(0, 1024), $urandom_range(0, 16));
    endtask

    task automatic add_pops(input int pop_pct);
        int k;
        k = 0;
        while (k < 8 && $urandom_range(0, 99) < pop_pct)
        begin
            add_pop();
            k++;
        end
    endtask

    // Head plus sent data bytes, with the odd pop slipped in between
    task automatic add_message(input logic [BYTE_W-1:0] st, input int len, input int chan,
                               input int sent, input int pop_pct);
        add_item(MODE_HEAD, st, len, chan);
        for (int i = 0; i < sent; i++)
        begin
            if ($urandom_range(0, 399) < pop_pct)
                add_pop();
            add_item(MODE_DATA, rand_data(), $urandom_range(0, 1024), $urandom_range(0, 16));
        end
    endtask

    task automatic add_random_message(input int pop_pct);
        int kind;
        int len;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            // voice traffic; reuse status and channel half the time to hit running status
            if ($urandom_range(0, 1) == 0)
            begin
                gen_voice = BYTE_W'($urandom_range(8'h80, 8'hEF));
                r = $urandom_range(0, 99);
                gen_chan = r < 40 ? 0 : (r < 95 ? $urandom_range(1, 16) : $urandom_range(17, 31));
            end
            len = (gen_voice[7:4] == 4'hC || gen_voice[7:4] == 4'hD) ? 2 : 3;
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(1, 4);
            add_message(gen_voice, len, gen_chan, len - 1, pop_pct);
        end
        else if (kind < 65)
        begin
            len = $urandom_range(2, 24);
            add_message(SYSTEM_BASE, len, $urandom_range(0, 16), len - 1, pop_pct);
        end
        else if (kind < 72)
        begin
            len = $urandom_range(1, 3);
            add_message(BYTE_W'($urandom_range(8'hF1, 8'hF7)), len, $urandom_range(0, 16),
                        len - 1, pop_pct);
        end
        else if (kind < 82)
        begin
            len = $urandom_range(0, 9) == 0 ? 2 : 1;
            add_message(BYTE_W'($urandom_range(8'hF8, 8'hFF)), len, $urandom_range(0, 16),
                        len - 1, pop_pct);
        end
        else if (kind < 85)
        begin
            len = $urandom_range(1, 3);
            add_message(BYTE_W'($urandom_range(0, 8'h7F)), len, $urandom_range(0, 16),
                        len - 1, pop_pct);
        end
        else if (kind < 90)
        begin
            // may be too big for what is left; cut short so the next head abandons it
            add_message(BYTE_W'($urandom_range(8'h80, 8'hFF)), $urandom_range(900, 1024),
                        $urandom_range(0, 16), $urandom_range(0, 5), pop_pct);
        end
        else if (kind < 95)
        begin
            len = $urandom_range(3, 12);
            add_message(BYTE_W'($urandom_range(8'h80, 8'hF0)), len, $urandom_range(0, 16),
                        $urandom_range(0, len - 2), pop_pct);
        end
        else
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                add_item(MODE_DATA, rand_data(), $urandom_range(0, 1024), $urandom_range(0, 16));
            else if (r == 1)
                add_item(MODE_HEAD, BYTE_W'($urandom_range(0, 255)), 0, $urandom_range(0, 16));
            else
                add_item(MODE_UNUSED, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 1024),
                         $urandom_range(0, 31));
        end
        add_pops(pop_pct);
    endtask

    task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d %s: expected %0h, got %0h", results_seen, what, want, got);
        end
    endtask

    // Offer queued transactions; predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin : driver_proc
        midi_req_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_HEAD;
            data_byte <= '0;
            msg_length <= '0;
            force_channel <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        merge_item({mode, data_byte, msg_length,
                                                    force_channel}));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (midi_requests.size() != 0)
                begin
                    req = midi_requests[0];
                    midi_requests.delete(0);
                    mode <= req.mode;
                    data_byte <= req.data;
                    msg_length <= req.len;
                    force_channel <= req.chan;
                    in_valid <= 1'b1;
                    send_gap <= pick_gap(0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Take results, compare against the oldest prediction, throttle out_ready
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        merge_result_t want;
        int gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("byte_valid", CNT_W'(want.byte_valid), CNT_W'(byte_valid));
                    check_field("out_byte", CNT_W'(want.out_byte), CNT_W'(out_byte));
                    check_field("message_dropped", CNT_W'(want.dropped),
                                CNT_W'(message_dropped));
                    check_field("queue_level", CNT_W'(want.level), CNT_W'(queue_level));
                    check_field("dropped_total", want.dropped_total, dropped_total);
                    check_field("delivered_total", want.delivered_total, delivered_total);
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
                begin
                    // stall long enough for the input side to back up
                    hold_left <= HOLD_CYCLES;
                    out_ready <= 1'b0;
                end
                else
                begin
                    gap = pick_gap(1);
                    recv_gap <= gap;
                    out_ready <= (gap == 0);
                end
            end
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= (recv_gap == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // End the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus_proc
        int fill_bytes;
        int n;
        int target;
        rst_n = 1'b0;

        // Directed: empty pop, unused mode, zero length, stray byte, running status,
        // forced and out-of-range channels, open-message abandon, oversized drops
        add_pop();
        add_item(MODE_UNUSED, 8'hA5, 1024, 31);
        add_item(MODE_HEAD, 8'h90, 0, 3);
        add_item(MODE_DATA, 8'h55, 7, 0);
        add_item(MODE_HEAD, 8'h93, 3, 0);
        add_item(MODE_DATA, 8'h3C, 0, 0);
        add_item(MODE_DATA, 8'h7F, 0, 0);
        add_item(MODE_HEAD, 8'h93, 3, 0);
        add_item(MODE_DATA, 8'h00, 0, 0);
        add_item(MODE_DATA, 8'hFF, 0, 0);
        add_item(MODE_HEAD, 8'h9F, 2, 4);
        add_item(MODE_DATA, 8'h40, 0, 0);
        add_item(MODE_HEAD, 8'h85, 1, 17);
        add_item(MODE_HEAD, 8'hE0, 3, 16);
        add_item(MODE_DATA, 8'h01, 0, 0);
        add_item(MODE_HEAD, 8'h40, 1, 15);
        add_item(MODE_HEAD, 8'hFF, 1, 0);
        add_item(MODE_HEAD, SYSTEM_BASE, 1024, 0);
        add_item(MODE_DATA, 8'h12, 0, 0);
        add_item(MODE_HEAD, 8'hF7, 1023, 0);
        add_item(MODE_HEAD, 8'hC5, 2, 0);
        add_item(MODE_DATA, 8'h7F, 0, 0);
        repeat (4) add_pop();

        // Mixed traffic with the queue mostly shallow
        while (midi_requests.size() < 150)
            add_random_message(45);

        // Fill the queue with long system exclusive messages, then overflow it
        fill_bytes = 0;
        while (fill_bytes < 700)
        begin
            n = $urandom_range(120, 300);
            add_message(SYSTEM_BASE, n, $urandom_range(0, 16), n - 1, 0);
            fill_bytes += n;
        end
        add_message(SYSTEM_BASE, 400, 0, 4, 0);
        repeat (25) add_random_message(5);

        // Drain with pops dominating
        target = midi_requests.size() + 200;
        while (midi_requests.size() < target)
            add_random_message(85);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (midi_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
